### hdl/assert_macros.svh
// Assertion macros included by the matrix core RTL.
// Each use expands to one labeled concurrent assertion that reports by $error.
// Every macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg: shared constants and types for the square matrix multiply core
// Element stores sizes, field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Built matrix dimension and derived widths
  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int SIZE_W  = 5;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ENTRY_W = 38;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Size register reset value
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Dot product sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Sequencer controls
  typedef struct packed {
    logic in_stall;
    logic issue;
    logic load_out;
  } ctrl_t;

endpackage

### hdl/square_matrix_multiply_core.sv
`timescale 1ns / 1ps
// Writes: a write word is stored when accepted; the core takes one write word per cycle while idle.
// Computes: a compute word walks n element pairs (n = size_in_use, capped at 16) through the
//   single shared multiply-accumulate unit; no new word is accepted until its result is loaded
//   into the output register, and with n = 0 the result is zero.
// Reset: synchronous active-low rst_n clears control state and sets size_in_use to 16;
//   the element stores are not cleared and read undefined until written.
// ----------------------------------------------------------------------------
// square_matrix_multiply_core: C = A x B, one entry of C per compute word
// Load words fill the A and B element stores; a compute word runs row i of A
// against column j of B through one shared Q8.8 multiply-accumulate unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module square_matrix_multiply_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration
  input  logic                                cfg_we,
  input  logic [smm_pkg::SIZE_W-1:0]          cfg_size_in_use,
  // Input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smm_pkg::OP_W-1:0]            in_operation,
  input  logic [smm_pkg::POS_W-1:0]           in_row,
  input  logic [smm_pkg::POS_W-1:0]           in_col,
  input  logic signed [smm_pkg::ELEM_W-1:0]   in_value,
  // Result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [smm_pkg::POS_W-1:0]           out_row,
  output logic [smm_pkg::POS_W-1:0]           out_col,
  output logic signed [smm_pkg::ENTRY_W-1:0]  out_product_entry
);
  import smm_pkg::*;

  // Element stores
  logic [ELEM_W-1:0] left_mem  [DEPTH];
  logic [ELEM_W-1:0] right_mem [DEPTH];

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic [SIZE_W-1:0]         size_r;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          n_cap;
  logic [CNT_W-1:0]          k_r;
  logic                      k_last;
  logic [POS_W-1:0]          row_r;
  logic [POS_W-1:0]          col_r;
  logic                      accept;
  logic                      is_compute;
  logic                      wr_left;
  logic                      wr_right;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ADDR_W-1:0]         rd_addr_left;
  logic [ADDR_W-1:0]         rd_addr_right;
  logic signed [ELEM_W-1:0]  rd_left_r;
  logic signed [ELEM_W-1:0]  rd_right_r;
  logic                      rd_vld_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      prod_vld_r;
  logic signed [ENTRY_W-1:0] acc_r;
  logic                      out_valid_r;
  logic [POS_W-1:0]          out_row_r;
  logic [POS_W-1:0]          out_col_r;
  logic signed [ENTRY_W-1:0] out_entry_r;
  logic                      out_free;
  logic                      pipe_empty;

  // Decode the accepted word
  assign accept     = in_valid && !ctrl.in_stall;
  assign is_compute = (in_operation == OP_COMPUTE);
  assign wr_left    = accept && (in_operation == OP_WRITE_A);
  assign wr_right   = accept && (in_operation == OP_WRITE_B);
  assign wr_addr    = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};

  // Saturate the configured size to the built dimension
  assign n_cap = (size_r > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(size_r);

  // Read addresses walk along row i of A and column j of B
  assign rd_addr_left  = {row_r[IDX_W-1:0], k_r[IDX_W-1:0]};
  assign rd_addr_right = {k_r[IDX_W-1:0], col_r[IDX_W-1:0]};
  assign k_last        = (k_r == (n_r - CNT_W'(1)));

  assign pipe_empty = !rd_vld_r && !prod_vld_r;
  assign out_free   = !out_valid_r || !out_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_size_in_use;
    end
  end

  // Left store: write on load words, registered read during the walk
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_addr] <= in_value;
    end
    rd_left_r <= left_mem[rd_addr_left];
  end

  // Right store
  always_ff @(posedge clk) begin
    if (wr_right) begin
      right_mem[wr_addr] <= in_value;
    end
    rd_right_r <= right_mem[rd_addr_right];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_compute) begin
          state_nxt = (n_cap == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:  ctrl.in_stall = 1'b0;
      ST_RUN: begin
        ctrl.in_stall = 1'b1;
        ctrl.issue    = 1'b1;
      end
      ST_DRAIN: begin
        ctrl.in_stall = 1'b1;
        ctrl.load_out = pipe_empty && out_free;
      end
      default:  ctrl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the compute word and advance the element index
  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      row_r <= in_row;
      col_r <= in_col;
      n_r   <= n_cap;
      k_r   <= '0;
    end else if (ctrl.issue) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  // Multiply-accumulate pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= ctrl.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  // Shared multiplier, then accumulate the exact Q22.16 sum
  always_ff @(posedge clk) begin
    prod_r <= rd_left_r * rd_right_r;
    if (accept && is_compute) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(ENTRY_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_entry_r <= acc_r;
    end
  end

  assign in_stall          = ctrl.in_stall;
  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_entry = out_entry_r;

  // Checks
  `ASSERT_SAME(a_pipe_busy, (rd_vld_r || prod_vld_r), (state_r != ST_IDLE), "MAC busy while idle")
  `ASSERT_SAME(a_load_drained, ctrl.load_out, pipe_empty, "result loaded before MAC drained")
  `ASSERT_SAME(a_issue_range, ctrl.issue, (k_r < n_r), "element index past size")
  `ASSERT_NEXT(a_load_shows, ctrl.load_out, out_valid_r, "loaded result not presented")

endmodule

### tb/square_matrix_multiply_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_core_tb: self-checking bench for the matrix core
// Loads A and B elements, asks for entries of C and checks every result word
// against an in-bench Q8.8 dot-product predictor or a typed entry, under random idling on
// both channels, a long output hold-off and several matrix sizes.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core_tb;
  import smm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CONFIG_PAD     = 24;    // quiet margin before a size write
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 500;

  typedef enum logic {STEP_WORD, STEP_SIZE} step_kind_t;

  typedef struct packed {
    step_kind_t                kind;
    logic [OP_W-1:0]           op;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic [ELEM_W-1:0]         value;
    logic                      typed;
    logic signed [ENTRY_W-1:0] entry;
  } step_t;

  typedef struct {
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [ENTRY_W-1:0] entry;
  } c_entry_t;

  // DUT ports
  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [SIZE_W-1:0]          cfg_size_in_use = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OP_W-1:0]            in_operation = '0;
  logic [POS_W-1:0]           in_row = '0;
  logic [POS_W-1:0]           in_col = '0;
  logic signed [ELEM_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [POS_W-1:0]           out_row;
  logic [POS_W-1:0]           out_col;
  logic signed [ENTRY_W-1:0]  out_product_entry;

  // Predictor state
  logic signed [ELEM_W-1:0] left_store  [DEPTH];
  logic signed [ELEM_W-1:0] right_store [DEPTH];
  bit                       left_set    [DEPTH];
  bit                       right_set   [DEPTH];
  logic [SIZE_W-1:0]        size_reg = SIZE_RESET;
  c_entry_t                 pending_entries [$];

  int mismatches    = 0;
  int words_counted = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Directed words: extremes, unused code, empty sum, typed entries where obvious
  step_t directed_steps [0:22] = '{
    '{STEP_SIZE, OP_WRITE_A, 4'd0,  4'd0,  16'h0001, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_A, 4'd0,  4'd0,  16'h7FFF, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_B, 4'd0,  4'd0,  16'h7FFF, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd0,  4'd0,  16'h0000, 1'b1, 38'sh003FFF0001},
    '{STEP_WORD, OP_WRITE_A, 4'd15, 4'd0,  16'h8000, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_B, 4'd0,  4'd15, 16'h8000, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd15, 16'h0000, 1'b1, 38'sh0040000000},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd0,  16'h0000, 1'b1, -38'sd1073709056},
    '{STEP_WORD, OP_COMPUTE, 4'd0,  4'd15, 16'h0000, 1'b1, -38'sd1073709056},
    '{STEP_WORD, OP_UNUSED,  4'd5,  4'd5,  16'h1234, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_A, 4'd0,  4'd0,  16'h0000, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd0,  4'd0,  16'hFFFF, 1'b1, 38'sd0},
    '{STEP_SIZE, OP_WRITE_A, 4'd0,  4'd0,  16'h0000, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd9,  4'd3,  16'h0000, 1'b1, 38'sd0},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd15, 16'h0000, 1'b1, 38'sd0},
    '{STEP_SIZE, OP_WRITE_A, 4'd0,  4'd0,  16'h0002, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_A, 4'd15, 4'd1,  16'h8000, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_B, 4'd1,  4'd15, 16'h8000, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd15, 16'h0000, 1'b1, 38'sh0080000000},
    '{STEP_WORD, OP_WRITE_A, 4'd15, 4'd1,  16'h0100, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd15, 16'h0000, 1'b0, '0},
    '{STEP_WORD, OP_WRITE_B, 4'd1,  4'd15, 16'h7FFF, 1'b0, '0},
    '{STEP_WORD, OP_COMPUTE, 4'd15, 4'd15, 16'h5A5A, 1'b0, '0}
  };

  // Sizes visited by the random part, then random ones
  logic [SIZE_W-1:0] size_plan [9] = '{5'd3, 5'd31, 5'd1, 5'd17, 5'd0, 5'd16, 5'd2,
                                       5'd8, 5'd5};

  square_matrix_multiply_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_size_in_use   (cfg_size_in_use),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_entry (out_product_entry)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Matrix dimension actually walked, saturated at the built size
  function automatic int effective_size();
    return (int'(size_reg) > MAX_DIM) ? MAX_DIM : int'(size_reg);
  endfunction

  // Exact Q22.16 sum of row of A against column of B
  function automatic logic signed [ENTRY_W-1:0] dot_entry(logic [POS_W-1:0] row,
                                                           logic [POS_W-1:0] col);
    longint acc;
    int     n;
    acc = 0;
    n   = effective_size();
    for (int k = 0; k < n; k++) begin
      acc += longint'(left_store[int'(row) * MAX_DIM + k]) *
             longint'(right_store[k * MAX_DIM + int'(col)]);
    end
    return acc[ENTRY_W-1:0];
  endfunction

  // Update stores or queue the entry for one accepted word
  function automatic void predict_word(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                                       logic [POS_W-1:0] col, logic [ELEM_W-1:0] value,
                                       logic typed, logic signed [ENTRY_W-1:0] entry);
    c_entry_t e;
    int       idx;
    idx = int'(row) * MAX_DIM + int'(col);
    if (op != OP_UNUSED) words_counted++;
    case (op)
      OP_WRITE_A: begin
        left_store[idx] = value;
        left_set[idx]   = 1'b1;
      end
      OP_WRITE_B: begin
        right_store[idx] = value;
        right_set[idx]   = 1'b1;
      end
      OP_COMPUTE: begin
        e.row   = row;
        e.col   = col;
        e.entry = typed ? entry : dot_entry(row, col);
        pending_entries.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] element_value();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic [ELEM_W-1:0] value,
                           input logic typed, input logic signed [ENTRY_W-1:0] entry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_row       <= row;
    in_col       <= col;
    in_value     <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, row, col, value, typed, entry);
  endtask

  // Drop valid and wait until every queued entry has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  // Write the size register once the core is idle
  task automatic set_size(input logic [SIZE_W-1:0] size);
    drain_results();
    repeat (CONFIG_PAD) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_size_in_use <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg  = size;
  endtask

  // Load any element the entry needs that was never written, then ask for it
  task automatic issue_compute(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    int n;
    n = effective_size();
    for (int k = 0; k < n; k++) begin
      if (!left_set[int'(row) * MAX_DIM + k])
        send_word(OP_WRITE_A, row, POS_W'(k), element_value(), 1'b0, '0);
      if (!right_set[k * MAX_DIM + int'(col)])
        send_word(OP_WRITE_B, POS_W'(k), col, element_value(), 1'b0, '0);
    end
    send_word(OP_COMPUTE, row, col, ELEM_W'($urandom), 1'b0, '0);
  endtask

  // Mostly computes with loads in front, some free loads, a little noise
  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      issue_compute(POS_W'($urandom), POS_W'($urandom));
    else if (pick < 75)
      send_word(OP_WRITE_A, POS_W'($urandom), POS_W'($urandom), element_value(), 1'b0, '0);
    else if (pick < 95)
      send_word(OP_WRITE_B, POS_W'($urandom), POS_W'($urandom), element_value(), 1'b0, '0);
    else
      send_word(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom),
                1'b0, '0);
  endtask

  // Receiver: long hold-off on request, random stall otherwise
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expected entry
  always @(posedge clk) begin
    c_entry_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word row %0d col %0d entry %0d", $time,
                 out_row, out_col, out_product_entry);
      end else begin
        e = pending_entries.pop_front();
        if (out_row !== e.row) begin
          mismatches++;
          $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
        end
        if (out_col !== e.col) begin
          mismatches++;
          $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
        end
        if (out_product_entry !== e.entry) begin
          mismatches++;
          $display("%0t: out_product_entry expected %0d actual %0d", $time, e.entry,
                   out_product_entry);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d entries pending", $time,
               pending_entries.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int plan_idx;
    int next_size_at;
    int phase_end;
    plan_idx     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size: a full row against a full column
    send_idle_pct = 38;
    recv_idle_pct = 64;
    issue_compute(POS_W'($urandom), POS_W'($urandom));

    // Directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_SIZE)
        set_size(directed_steps[i].value[SIZE_W-1:0]);
      else
        send_word(directed_steps[i].op, directed_steps[i].row, directed_steps[i].col,
                  directed_steps[i].value, directed_steps[i].typed,
                  directed_steps[i].entry);
    end

    // Random part in three idling modes, resizing every few dozen words
    next_size_at = words_counted;
    phase_end    = words_counted;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_end += RANDOM_WORDS / 3;

      // Long output hold-off while computes keep coming, then a full pause
      if (phase == 2) begin
        hold_req++;
        repeat (16) issue_compute(POS_W'($urandom), POS_W'($urandom));
        drain_results();
      end

      while (words_counted < phase_end) begin
        if (words_counted >= next_size_at) begin
          if (plan_idx < $size(size_plan))
            set_size(size_plan[plan_idx]);
          else
            set_size(SIZE_W'($urandom_range(31)));
          plan_idx++;
          next_size_at = words_counted + 45;
        end
        random_word();
      end
    end

    // Drain and let the core settle before the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
